// ===== src/kec_pkg.sv =====
// Package for the keyed entry table: field widths, operation and status codes,
// and the structs passed between the top level and its cells. No dependencies.
package kec_pkg;

    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 16;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic cmp_en;
        logic in_range;
        logic is_last;
        logic ins_en;
        logic mov_en;
    } kec_ctl_t;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] hit_handle;
        logic [KEY_W-1:0]    last_key;
        logic [HANDLE_W-1:0] last_handle;
    } kec_chain_t;

endpackage

// ===== src/kec_req_if.sv =====
// Request channel of the keyed entry table: valid, ready and the request beat.
// Depends on kec_pkg.
interface kec_req_if;
    logic                          valid;
    logic                          ready;
    logic [kec_pkg::FUNC_W-1:0]    func;
    logic [kec_pkg::KEY_W-1:0]     key;
    logic [kec_pkg::HANDLE_W-1:0]  entry_handle;

    modport source (output valid, output func, output key, output entry_handle, input ready);
    modport sink (input valid, input func, input key, input entry_handle, output ready);
endinterface

// ===== src/kec_rsp_if.sv =====
// Response channel of the keyed entry table: valid, ready and the result beat.
// Depends on kec_pkg.
interface kec_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [kec_pkg::STATUS_W-1:0]  status;
    logic [kec_pkg::HANDLE_W-1:0]  found_handle;
    logic [kec_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, output status, output found_handle, output occupancy,
                    input ready);
    modport sink (input valid, input status, input found_handle, input occupancy,
                  output ready);
endinterface

// ===== src/kec_cell.sv =====
// One slot of the keyed entry table: stored key and handle, a registered match
// flag, and its stage of the result chain. Depends on kec_pkg.
module kec_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kec_pkg::kec_ctl_t             ctl,
    input  logic [kec_pkg::KEY_W-1:0]     cmp_key,
    input  logic [kec_pkg::KEY_W-1:0]     wr_key,
    input  logic [kec_pkg::HANDLE_W-1:0]  wr_handle,
    input  kec_pkg::kec_chain_t           chain_in,
    output kec_pkg::kec_chain_t           chain_out
);

    logic [kec_pkg::KEY_W-1:0]    key_reg;
    logic [kec_pkg::HANDLE_W-1:0] handle_reg;
    logic                         match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            match_reg <= ctl.in_range && (key_reg == cmp_key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ins_en || (ctl.mov_en && match_reg))
        begin
            key_reg    <= wr_key;
            handle_reg <= wr_handle;
        end
    end

    always_comb
    begin
        chain_out = chain_in;
        if (match_reg)
        begin
            chain_out.hit        = 1'b1;
            chain_out.hit_handle = chain_in.hit_handle | handle_reg;
        end
        if (ctl.is_last)
        begin
            chain_out.last_key    = chain_in.last_key | key_reg;
            chain_out.last_handle = chain_in.last_handle | handle_reg;
        end
    end

endmodule

// ===== src/keyed_entry_table.sv =====
// Top level of the keyed entry table, built from kec_cell slots; uses kec_pkg and the
// kec_req_if and kec_rsp_if channels.
//
// A table of up to CAPACITY unique 64-bit keys, each with a 16-bit handle, held packed
// in a row of cells. Each request beat is a lookup, an insert or a remove and yields
// one response beat with a status, the found handle and the occupancy after the
// request. On acceptance every cell compares the key and registers its match; once the
// output register is free, the match and the last entry ripple down the cell row and
// the result is resolved into that register. A removed entry is replaced by the last
// one. Requests are handled one at a time; a new request is accepted while the
// previous response still waits in the output register.
module keyed_entry_table #(
    parameter int CAPACITY = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    kec_req_if.sink  req,
    kec_rsp_if.source rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_RESOLVE = 1'b1;

    logic                          state_reg;
    logic [kec_pkg::FUNC_W-1:0]    func_reg;
    logic [kec_pkg::KEY_W-1:0]     rkey_reg;
    logic [kec_pkg::HANDLE_W-1:0]  rhandle_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          rsp_valid_reg;
    logic [kec_pkg::STATUS_W-1:0]  status_reg;
    logic [kec_pkg::STATUS_W-1:0]  status_next;
    logic [kec_pkg::HANDLE_W-1:0]  found_reg;
    logic [kec_pkg::HANDLE_W-1:0]  found_next;

    logic                          accept;
    logic                          fire;
    logic                          ins_ok;
    logic                          mov_ok;
    logic [kec_pkg::KEY_W-1:0]     wr_key;
    logic [kec_pkg::HANDLE_W-1:0]  wr_handle;
    kec_pkg::kec_chain_t           chain [CAPACITY+1];
    kec_pkg::kec_chain_t           tail;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign fire      = (state_reg == ST_RESOLVE) && (!rsp_valid_reg || rsp.ready);
    assign chain[0]  = '0;
    assign tail      = chain[CAPACITY];

    always_comb
    begin
        status_next = kec_pkg::STATUS_NOT_FOUND;
        found_next  = '0;
        count_next  = count_reg;
        ins_ok      = 1'b0;
        mov_ok      = 1'b0;
        case (func_reg)
            kec_pkg::FUNC_LOOKUP:
            begin
                if (tail.hit)
                begin
                    status_next = kec_pkg::STATUS_OK;
                    found_next  = tail.hit_handle;
                end
            end
            kec_pkg::FUNC_INSERT:
            begin
                if (count_reg == CW'(CAPACITY))
                begin
                    status_next = kec_pkg::STATUS_FULL;
                end
                else if (tail.hit)
                begin
                    status_next = kec_pkg::STATUS_DUPLICATE;
                end
                else
                begin
                    status_next = kec_pkg::STATUS_OK;
                    count_next  = count_reg + CW'(1);
                    ins_ok      = 1'b1;
                end
            end
            kec_pkg::FUNC_REMOVE:
            begin
                if (tail.hit)
                begin
                    status_next = kec_pkg::STATUS_OK;
                    found_next  = tail.hit_handle;
                    count_next  = count_reg - CW'(1);
                    mov_ok      = 1'b1;
                end
            end
            default:
            begin
                status_next = kec_pkg::STATUS_NOT_FOUND;
            end
        endcase
    end

    assign wr_key    = (func_reg == kec_pkg::FUNC_INSERT) ? rkey_reg : tail.last_key;
    assign wr_handle = (func_reg == kec_pkg::FUNC_INSERT) ? rhandle_reg : tail.last_handle;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        kec_pkg::kec_ctl_t ctl;

        always_comb
        begin
            ctl.cmp_en   = accept;
            ctl.in_range = (CW'(i) < count_reg);
            ctl.is_last  = (CW'(i + 1) == count_reg);
            ctl.ins_en   = fire && ins_ok && (CW'(i) == count_reg);
            ctl.mov_en   = fire && mov_ok;
        end

        kec_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .cmp_key   (req.key),
            .wr_key    (wr_key),
            .wr_handle (wr_handle),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= ST_RESOLVE;
            end
            else if (fire)
            begin
                state_reg <= ST_IDLE;
            end
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= req.func;
            rkey_reg    <= req.key;
            rhandle_reg <= req.entry_handle;
        end
        if (fire)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    logic [kec_pkg::OCC_W-1:0] occ_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            occ_reg <= kec_pkg::OCC_W'(count_next);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.found_handle = found_reg;
    assign rsp.occupancy    = occ_reg;

endmodule

// ===== src/kec_checker.sv =====
// Port-level checker for the keyed entry table and the bind that attaches it.
// Depends on kec_pkg and keyed_entry_table.
module kec_checker #(
    parameter int CAPACITY = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [kec_pkg::STATUS_W-1:0]  rsp_status,
    input logic [kec_pkg::HANDLE_W-1:0]  rsp_found_handle,
    input logic [kec_pkg::OCC_W-1:0]     rsp_occupancy
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_found_handle) && $stable(rsp_occupancy))
        else $error("Stalled response beat changed.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Request accepted while another is in progress.");

    a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != kec_pkg::STATUS_OK |-> rsp_found_handle == '0)
        else $error("Failed request returned a nonzero handle.");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == kec_pkg::STATUS_FULL
            |-> rsp_occupancy == kec_pkg::OCC_W'(CAPACITY))
        else $error("Table full reported below capacity.");

endmodule

bind keyed_entry_table kec_checker #(.CAPACITY(CAPACITY)) u_kec_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_found_handle (rsp.found_handle),
    .rsp_occupancy    (rsp.occupancy)
);

// ===== tb/tb.sv =====
// Self-checking testbench for keyed_entry_table: lookups, inserts and removes against
// a behavioral table model, with random idling on requests and back-pressure on responses.
// Depends on kec_pkg, kec_req_if, kec_rsp_if and the keyed_entry_table RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kec_pkg::*;

    localparam int TABLE_SLOTS     = 16;
    localparam int ITEMS_PER_PHASE = 410;
    localparam int NUM_PHASES      = 4;
    localparam int FILL_SPAN       = 60;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] found_handle;
        logic [OCC_W-1:0]    occupancy;
    } table_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic                typed;
        table_result_t       result;
    } table_row_t;

    logic clk;
    logic rst_n;

    kec_req_if req();
    kec_rsp_if rsp();

    keyed_entry_table #(.CAPACITY(TABLE_SLOTS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [KEY_W-1:0]    model_keys[TABLE_SLOTS];
    logic [HANDLE_W-1:0] model_handles[TABLE_SLOTS];
    int                  model_count = 0;
    table_result_t       pending_results[$];
    table_row_t          directed_rows[$];
    logic [KEY_W-1:0]    key_pool[16];

    int sender_idle_pct  = 0;
    int rsp_stall_pct    = 0;
    int rsp_hold_request = 0;
    int error_count      = 0;
    int accepted_count   = 0;
    int full_hits        = 0;
    int empty_hits       = 0;
    int status_seen[4]   = '{0, 0, 0, 0};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function automatic table_result_t apply_request(input logic [FUNC_W-1:0] func,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [HANDLE_W-1:0] handle);
        table_result_t r;
        int            slot;
        r.status       = STATUS_NOT_FOUND;
        r.found_handle = '0;
        slot           = TABLE_SLOTS;
        for (int i = model_count - 1; i >= 0; i--)
            if (model_keys[i] == key)
                slot = i;
        case (func)
            FUNC_LOOKUP:
                if (slot < TABLE_SLOTS)
                begin
                    r.status       = STATUS_OK;
                    r.found_handle = model_handles[slot];
                end
            FUNC_INSERT:
                if (model_count >= TABLE_SLOTS)
                    r.status = STATUS_FULL;
                else if (slot < TABLE_SLOTS)
                    r.status = STATUS_DUPLICATE;
                else
                begin
                    model_keys[model_count]    = key;
                    model_handles[model_count] = handle;
                    model_count++;
                    r.status = STATUS_OK;
                end
            FUNC_REMOVE:
                if (slot < TABLE_SLOTS)
                begin
                    r.found_handle = model_handles[slot];
                    model_count--;
                    model_keys[slot]    = model_keys[model_count];
                    model_handles[slot] = model_handles[model_count];
                    r.status = STATUS_OK;
                end
            default:
                r.status = STATUS_NOT_FOUND;
        endcase
        r.occupancy = OCC_W'(model_count);
        return r;
    endfunction

    function automatic void add_row(input logic [FUNC_W-1:0] func,
                                    input logic [KEY_W-1:0] key,
                                    input logic [HANDLE_W-1:0] handle,
                                    input logic typed,
                                    input logic [STATUS_W-1:0] status,
                                    input logic [HANDLE_W-1:0] found_handle,
                                    input logic [OCC_W-1:0] occupancy);
        table_row_t row;
        row.func                = func;
        row.key                 = key;
        row.handle              = handle;
        row.typed               = typed;
        row.result.status       = status;
        row.result.found_handle = found_handle;
        row.result.occupancy    = occupancy;
        directed_rows.push_back(row);
    endfunction

    function automatic table_row_t random_request(input bit fill_phase);
        table_row_t row;
        int         r;
        int         pick;
        r = $urandom_range(99);
        if (r < 4)
            row.func = FUNC_UNUSED;
        else if (r < 28)
            row.func = FUNC_LOOKUP;
        else if (r < (fill_phase ? 80 : 42))
            row.func = FUNC_INSERT;
        else
            row.func = FUNC_REMOVE;
        pick = $urandom_range(99);
        if (model_count > 0 && pick < (row.func == FUNC_INSERT ? 15 : 60))
            row.key = model_keys[$urandom_range(model_count - 1)];
        else if (model_count > 0 && pick < 75)
            row.key = model_keys[$urandom_range(model_count - 1)]
                      ^ (64'd1 << $urandom_range(KEY_W - 1));
        else if (pick < 90)
            row.key = key_pool[$urandom_range(15)];
        else
            row.key = {$urandom, $urandom};
        row.handle = HANDLE_W'($urandom);
        row.typed  = 1'b0;
        row.result = '0;
        return row;
    endfunction

    task automatic offer_request(input table_row_t row);
        table_result_t predicted;
        int            gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid        <= 1'b0;
            req.key          <= {$urandom, $urandom};
            req.entry_handle <= HANDLE_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        req.valid        <= 1'b1;
        req.func         <= row.func;
        req.key          <= row.key;
        req.entry_handle <= row.handle;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predicted = apply_request(row.func, row.key, row.handle);
        pending_results.push_back(row.typed ? row.result : predicted);
        accepted_count++;
        status_seen[predicted.status]++;
        if (predicted.status == STATUS_OK && row.func == FUNC_INSERT
            && model_count == TABLE_SLOTS)
            full_hits++;
        if (predicted.status == STATUS_OK && row.func == FUNC_REMOVE && model_count == 0)
            empty_hits++;
    endtask

    always @(posedge clk)
    begin : check_results
        table_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected beat: status %0d handle %h occupancy %0d",
                                          rsp.status, rsp.found_handle, rsp.occupancy));
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              rsp.status, want.status));
                if (rsp.found_handle !== want.found_handle)
                    report_mismatch($sformatf("found_handle %h, wanted %h",
                                              rsp.found_handle, want.found_handle));
                if (rsp.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, wanted %0d",
                                              rsp.occupancy, want.occupancy));
            end
        end
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_request > 0)
            begin
                hold_left        = rsp_hold_request;
                rsp_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        req.valid        <= 1'b0;
        req.func         <= FUNC_LOOKUP;
        req.key          <= '0;
        req.entry_handle <= '0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        key_pool[3] = 64'h0000_0000_0000_0001;
        for (int i = 4; i < 16; i++)
            key_pool[i] = {$urandom, $urandom};

        add_row(FUNC_LOOKUP, '0, 16'h0000, 1'b1, STATUS_NOT_FOUND, 16'h0000, 5'd0);
        add_row(FUNC_REMOVE, '1, 16'hffff, 1'b1, STATUS_NOT_FOUND, 16'h0000, 5'd0);
        add_row(FUNC_UNUSED, 64'h5555_5555_5555_5555, 16'haaaa, 1'b1,
                STATUS_NOT_FOUND, 16'h0000, 5'd0);
        add_row(FUNC_INSERT, '0, 16'h0000, 1'b1, STATUS_OK, 16'h0000, 5'd1);
        add_row(FUNC_INSERT, '1, 16'hffff, 1'b1, STATUS_OK, 16'h0000, 5'd2);
        add_row(FUNC_INSERT, '0, 16'h1234, 1'b1, STATUS_DUPLICATE, 16'h0000, 5'd2);
        add_row(FUNC_LOOKUP, '1, 16'h0000, 1'b1, STATUS_OK, 16'hffff, 5'd2);
        for (int i = 0; i < TABLE_SLOTS - 2; i++)
            add_row(FUNC_INSERT, 64'h0123_4567_89ab_cd00 + i, HANDLE_W'(16'h0100 + i),
                    1'b0, STATUS_OK, 16'h0000, 5'd0);
        add_row(FUNC_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 16'h7777, 1'b1,
                STATUS_FULL, 16'h0000, 5'd16);
        add_row(FUNC_INSERT, '0, 16'h0000, 1'b1, STATUS_FULL, 16'h0000, 5'd16);
        add_row(FUNC_REMOVE, '1, 16'h0000, 1'b1, STATUS_OK, 16'hffff, 5'd15);
        add_row(FUNC_LOOKUP, 64'h0123_4567_89ab_cd0d, 16'h0000, 1'b0,
                STATUS_OK, 16'h0000, 5'd0);
        add_row(FUNC_UNUSED, '0, 16'h0000, 1'b1, STATUS_NOT_FOUND, 16'h0000, 5'd15);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_request(directed_rows[i]);
        @(negedge clk);
        req.valid <= 1'b0;
        wait (pending_results.size() == 0);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    rsp_stall_pct   = 0;
                end
                1:
                begin
                    sender_idle_pct = 48;
                    rsp_stall_pct   = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    rsp_stall_pct   = 48;
                end
                default:
                begin
                    sender_idle_pct = 7;
                    rsp_stall_pct   = 7;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // The response side freezes while requests keep coming, so the
                // table backs up and must hold off its request channel.
                if (phase == 0 && n == 100)
                    rsp_hold_request = 80;
                offer_request(random_request(((n / FILL_SPAN) % 2) == 0));
            end
            @(negedge clk);
            req.valid <= 1'b0;
            wait (pending_results.size() == 0);
        end

        repeat (12) @(posedge clk);
        $display("covered %0d requests: %0d ok, %0d not found, %0d duplicate, %0d full",
                 accepted_count, status_seen[STATUS_OK], status_seen[STATUS_NOT_FOUND],
                 status_seen[STATUS_DUPLICATE], status_seen[STATUS_FULL]);
        $display("table filled %0d times and drained %0d times; %0d mismatches",
                 full_hits, empty_hits, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/kec_pkg.sv
src/kec_req_if.sv
src/kec_rsp_if.sv
src/kec_cell.sv
src/keyed_entry_table.sv
src/kec_checker.sv
tb/tb.sv
